@@ rtl/core/dbe_pkg.sv @@
// ----------------------------------------------------------------------------
// dbe_pkg
// Shared types, constants and helpers of the distance-bound error pair block.
// ----------------------------------------------------------------------------
package dbe_pkg;

  // fixed-point format of the coordinates
  localparam int COORD_FRAC_BITS = 20;

  // shift amounts applied after each multiply
  localparam logic [6:0] SH_SQ  = 7'(COORD_FRAC_BITS);
  localparam logic [6:0] SH_PRD = 7'(COORD_FRAC_BITS - 4);
  localparam logic [6:0] SH_POS = 7'd26;
  localparam logic [6:0] SH_32  = 7'd32;
  localparam logic [6:0] SH_T   = 7'd28;
  localparam logic [6:0] SH_NEG = 7'd31;

  // saturation limits
  localparam logic [63:0] CAP_NONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP_62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] CAP_63   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP_48   = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP_GPOS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] CAP_GNEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

  // divider: quotient bits of 2^65 / den, and starting remainder 2^31
  localparam int          DIV_STEPS = 34;
  localparam logic [63:0] DIV_SEED  = 64'h0000_0000_8000_0000;

  // multiply operations, in issue order
  typedef enum logic [3:0] {
    OP_SQ0, OP_SQ1, OP_SQ2, OP_SQ3,
    OP_PU, OP_PL, OP_POS, OP_Q2, OP_T, OP_NEG,
    OP_G0, OP_G1, OP_G2, OP_G3,
    OP_EU, OP_EL
  } mul_op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_DIV_INIT, ST_DIV, ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       pp_en;
    logic [1:0] pp_idx;
    logic       acc_clr;
    logic       acc_add;
    logic       wb;
    mul_op_t    op;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } dbe_cmd_t;

  // one pair request
  typedef struct packed {
    logic signed [3:0][31:0] pa;
    logic signed [3:0][31:0] pb;
    logic [31:0]             inv_lower_sq;
    logic [31:0]             inv_upper_sq;
    logic                    last_pair;
  } pair_t;

  // one result
  typedef struct packed {
    logic [3:0][31:0] grad;
    logic [47:0]      pair_error;
    logic [62:0]      total_error;
    logic             sweep_done;
  } result_t;

  // next multiply in the sequence
  function automatic mul_op_t next_op(input mul_op_t op);
    mul_op_t n;
    case (op)
      OP_SQ0:  n = OP_SQ1;
      OP_SQ1:  n = OP_SQ2;
      OP_SQ2:  n = OP_SQ3;
      OP_SQ3:  n = OP_PU;
      OP_PU:   n = OP_PL;
      OP_PL:   n = OP_POS;
      OP_POS:  n = OP_Q2;
      OP_Q2:   n = OP_T;
      OP_T:    n = OP_NEG;
      OP_NEG:  n = OP_G0;
      OP_G0:   n = OP_G1;
      OP_G1:   n = OP_G2;
      OP_G2:   n = OP_G3;
      OP_G3:   n = OP_EU;
      OP_EU:   n = OP_EL;
      default: n = OP_SQ0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/dbe_ifc.sv @@
// ----------------------------------------------------------------------------
// dbe_ifc
// Valid/ready channels for pair requests and results.
// ----------------------------------------------------------------------------
interface dbe_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_a_x;
  logic signed [31:0] point_a_y;
  logic signed [31:0] point_a_z;
  logic signed [31:0] point_a_w;
  logic signed [31:0] point_b_x;
  logic signed [31:0] point_b_y;
  logic signed [31:0] point_b_z;
  logic signed [31:0] point_b_w;
  logic [31:0]        inv_lower_sq;
  logic [31:0]        inv_upper_sq;
  logic               last_pair;

  modport source (
    output valid, point_a_x, point_a_y, point_a_z, point_a_w,
    output point_b_x, point_b_y, point_b_z, point_b_w,
    output inv_lower_sq, inv_upper_sq, last_pair,
    input  ready
  );
  modport sink (
    input  valid, point_a_x, point_a_y, point_a_z, point_a_w,
    input  point_b_x, point_b_y, point_b_z, point_b_w,
    input  inv_lower_sq, inv_upper_sq, last_pair,
    output ready
  );
endinterface

interface dbe_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;
  logic signed [31:0] grad_w;
  logic [47:0]        pair_error;
  logic [62:0]        total_error;
  logic               sweep_done;

  modport source (
    output valid, grad_x, grad_y, grad_z, grad_w,
    output pair_error, total_error, sweep_done,
    input  ready
  );
  modport sink (
    input  valid, grad_x, grad_y, grad_z, grad_w,
    input  pair_error, total_error, sweep_done,
    output ready
  );
endinterface

@@ rtl/core/distance_bound_error_pair.sv @@
// ----------------------------------------------------------------------------
// distance_bound_error_pair
// Distance-bound error and gradient for one atom pair per request.
// ----------------------------------------------------------------------------
// Usage:
//   The pair channel takes one request: two 4D points in signed Q12.20,
//   the inverse squared lower and upper bounds in Q4.28, and last_pair.
//   The result channel returns the saturated gradient (host adds it to
//   point a, subtracts it from point b), the pair error in Q16.32 and the
//   saturating running total including this pair; sweep_done echoes
//   last_pair, and the total is cleared after that result.
// Sequence:
//   One request at a time: sixteen multiplies on one shared 64x64
//   multiplier, each as four 32x32 partial products plus accumulate
//   and write-back, a one-bit-per-cycle divider for the lower-bound
//   quotient, and a final load of the result before the next request.
// Reset and stall:
//   Reset empties the result register and clears the running total.
//   A result waits in its output register while the receiver stalls; the
//   next request is already taken and worked, and only its final load
//   waits for the register to free up.
// ----------------------------------------------------------------------------
module distance_bound_error_pair (
  input  logic         clk,
  input  logic         rst,
  dbe_pair_if.sink     pair,
  dbe_result_if.source result
);

  dbe_pkg::dbe_cmd_t cmd;
  dbe_pkg::pair_t    pair_data;
  dbe_pkg::result_t  res_data;

  // pack the request
  assign pair_data.pa[0]        = pair.point_a_x;
  assign pair_data.pa[1]        = pair.point_a_y;
  assign pair_data.pa[2]        = pair.point_a_z;
  assign pair_data.pa[3]        = pair.point_a_w;
  assign pair_data.pb[0]        = pair.point_b_x;
  assign pair_data.pb[1]        = pair.point_b_y;
  assign pair_data.pb[2]        = pair.point_b_z;
  assign pair_data.pb[3]        = pair.point_b_w;
  assign pair_data.inv_lower_sq = pair.inv_lower_sq;
  assign pair_data.inv_upper_sq = pair.inv_upper_sq;
  assign pair_data.last_pair    = pair.last_pair;

  dbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pair.valid),
    .in_ready  (pair.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  dbe_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .pair   (pair_data),
    .result (res_data)
  );

  // unpack the result
  assign result.grad_x      = res_data.grad[0];
  assign result.grad_y      = res_data.grad[1];
  assign result.grad_z      = res_data.grad[2];
  assign result.grad_w      = res_data.grad[3];
  assign result.pair_error  = res_data.pair_error;
  assign result.total_error = res_data.total_error;
  assign result.sweep_done  = res_data.sweep_done;

endmodule

@@ rtl/core/dbe_mul.sv @@
// ----------------------------------------------------------------------------
// dbe_mul
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module dbe_mul (
  input  logic         clk,
  input  logic [63:0]  op_a,
  input  logic [63:0]  op_b,
  input  logic         pp_en,
  input  logic [1:0]   pp_idx,
  input  logic         acc_clr,
  input  logic         acc_add,
  output logic [127:0] prod
);

  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_wide;

  // pick the operand halves of this partial product
  assign a_half = pp_idx[1] ? op_a[63:32] : op_a[31:0];
  assign b_half = pp_idx[0] ? op_b[63:32] : op_b[31:0];

  // register the partial product and its weight
  always_ff @(posedge clk) begin
    if (pp_en) begin
      pp    <= {32'd0, a_half} * {32'd0, b_half};
      pp_sh <= 2'({1'b0, pp_idx[1]} + {1'b0, pp_idx[0]});
    end
  end

  always_comb begin
    case (pp_sh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (acc_clr) begin
      prod <= '0;
    end else if (acc_add) begin
      prod <= prod + pp_wide;
    end
  end

endmodule

@@ rtl/core/dbe_datapath.sv @@
// ----------------------------------------------------------------------------
// dbe_datapath
// Working registers, operand selection, write-back, divider and result register.
// ----------------------------------------------------------------------------
module dbe_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dbe_pkg::dbe_cmd_t cmd,
  input  dbe_pkg::pair_t    pair,
  output dbe_pkg::result_t  result
);

  logic [3:0][31:0] dmag;
  logic [3:0]       dneg;
  logic [31:0]      lbinv;
  logic [31:0]      ubinv;
  logic             last;
  logic [63:0]      d2;
  logic [63:0]      ub;
  logic [63:0]      den;
  logic [63:0]      rem;
  logic [33:0]      quo;
  logic [63:0]      pos;
  logic [63:0]      q2;
  logic [63:0]      tv;
  logic [63:0]      smag;
  logic             sneg;
  logic [3:0][31:0] grad;
  logic [63:0]      eu;
  logic [47:0]      pe;
  logic [62:0]      error_sum;

  logic [63:0]  op_a;
  logic [63:0]  op_b;
  logic [6:0]   sh;
  logic [63:0]  cap;
  logic [127:0] prod;
  logic [127:0] shifted;
  logic [63:0]  res;
  logic [63:0]  qext;
  logic [63:0]  lb;
  logic [1:0]   axis;
  logic         gneg;
  logic [64:0]  rem2;
  logic [64:0]  rem_sub;
  logic [63:0]  neg_val;
  logic [48:0]  pe_sum;
  logic [63:0]  tot_sum;
  logic [62:0]  tot;

  dbe_mul u_mul (
    .clk     (clk),
    .op_a    (op_a),
    .op_b    (op_b),
    .pp_en   (cmd.pp_en),
    .pp_idx  (cmd.pp_idx),
    .acc_clr (cmd.acc_clr),
    .acc_add (cmd.acc_add),
    .prod    (prod)
  );

  assign qext = {30'd0, quo};
  assign lb   = (qext > dbe_pkg::ONE_Q32) ? qext - dbe_pkg::ONE_Q32 : 64'd0;
  assign axis = cmd.op[1:0];
  assign gneg = dneg[axis] ^ sneg;

  // select operands, shift and limit per operation
  always_comb begin
    op_a = 64'd0;
    op_b = 64'd0;
    sh   = dbe_pkg::SH_32;
    cap  = dbe_pkg::CAP_62;
    case (cmd.op)
      dbe_pkg::OP_SQ0, dbe_pkg::OP_SQ1, dbe_pkg::OP_SQ2, dbe_pkg::OP_SQ3: begin
        op_a = {32'd0, dmag[axis]};
        op_b = {32'd0, dmag[axis]};
        sh   = dbe_pkg::SH_SQ;
        cap  = dbe_pkg::CAP_NONE;
      end
      dbe_pkg::OP_PU: begin
        op_a = d2;
        op_b = {32'd0, ubinv};
        sh   = dbe_pkg::SH_PRD;
      end
      dbe_pkg::OP_PL: begin
        op_a = d2;
        op_b = {32'd0, lbinv};
        sh   = dbe_pkg::SH_PRD;
        cap  = dbe_pkg::CAP_63;
      end
      dbe_pkg::OP_POS: begin
        op_a = {32'd0, ubinv};
        op_b = ub;
        sh   = dbe_pkg::SH_POS;
      end
      dbe_pkg::OP_Q2: begin
        op_a = qext;
        op_b = qext;
      end
      dbe_pkg::OP_T: begin
        op_a = q2;
        op_b = {32'd0, lbinv};
        sh   = dbe_pkg::SH_T;
      end
      dbe_pkg::OP_NEG: begin
        op_a = tv;
        op_b = lb;
        sh   = dbe_pkg::SH_NEG;
      end
      dbe_pkg::OP_G0, dbe_pkg::OP_G1, dbe_pkg::OP_G2, dbe_pkg::OP_G3: begin
        op_a = {32'd0, dmag[axis]};
        op_b = smag;
        cap  = gneg ? dbe_pkg::CAP_GNEG : dbe_pkg::CAP_GPOS;
      end
      dbe_pkg::OP_EU: begin
        op_a = ub;
        op_b = ub;
        cap  = dbe_pkg::CAP_48;
      end
      dbe_pkg::OP_EL: begin
        op_a = lb;
        op_b = lb;
        cap  = dbe_pkg::CAP_48;
      end
      default: begin
        op_a = 64'd0;
      end
    endcase
  end

  // scale and saturate the product
  assign shifted = prod >> sh;
  assign res     = (shifted > {64'd0, cap}) ? cap : shifted[63:0];
  assign neg_val = 64'd0 - res;

  // divider step
  assign rem2    = {rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, den};

  // error sums
  assign pe_sum  = {1'b0, eu[47:0]} + {1'b0, res[47:0]};
  assign tot_sum = {1'b0, error_sum} + {16'd0, pe};
  assign tot     = tot_sum[63] ? dbe_pkg::CAP_63[62:0] : tot_sum[62:0];

  // capture the pair and run the write-back of each operation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 4; i++) begin
        logic signed [32:0] df;
        df = {pair.pa[i][31], pair.pa[i]} - {pair.pb[i][31], pair.pb[i]};
        dneg[i] <= df[32];
        dmag[i] <= df[32] ? 32'(-df) : df[31:0];
      end
      lbinv <= pair.inv_lower_sq;
      ubinv <= pair.inv_upper_sq;
      last  <= pair.last_pair;
      d2    <= 64'd0;
    end
    if (cmd.wb) begin
      case (cmd.op)
        dbe_pkg::OP_SQ0, dbe_pkg::OP_SQ1, dbe_pkg::OP_SQ2, dbe_pkg::OP_SQ3: begin
          d2 <= d2 + res;
        end
        dbe_pkg::OP_PU:  ub  <= (res > dbe_pkg::ONE_Q32) ? res - dbe_pkg::ONE_Q32 : 64'd0;
        dbe_pkg::OP_PL:  den <= dbe_pkg::ONE_Q32 + res;
        dbe_pkg::OP_POS: pos <= res;
        dbe_pkg::OP_Q2:  q2  <= res;
        dbe_pkg::OP_T:   tv  <= res;
        dbe_pkg::OP_NEG: begin
          sneg <= (res > pos);
          smag <= (res > pos) ? res - pos : pos - res;
        end
        dbe_pkg::OP_G0, dbe_pkg::OP_G1, dbe_pkg::OP_G2, dbe_pkg::OP_G3: begin
          grad[axis] <= gneg ? neg_val[31:0] : res[31:0];
        end
        dbe_pkg::OP_EU:  eu <= res;
        dbe_pkg::OP_EL:  pe <= pe_sum[48] ? dbe_pkg::CAP_48[47:0] : pe_sum[47:0];
        default:         eu <= eu;
      endcase
    end
    // restoring division of 2^65 by den
    if (cmd.div_init) begin
      rem <= dbe_pkg::DIV_SEED;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[64]) begin
        rem <= rem_sub[63:0];
        quo <= {quo[32:0], 1'b1};
      end else begin
        rem <= rem2[63:0];
        quo <= {quo[32:0], 1'b0};
      end
    end
    // load the result register
    if (cmd.out_load) begin
      result.grad        <= grad;
      result.pair_error  <= pe;
      result.total_error <= tot;
      result.sweep_done  <= last;
    end
  end

  // running total
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (cmd.out_load) begin
      error_sum <= last ? 63'd0 : tot;
    end
  end

endmodule

@@ rtl/core/dbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// dbe_ctrl
// Sequencer for the multiply list, the divider and the result handshake.
// ----------------------------------------------------------------------------
module dbe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dbe_pkg::dbe_cmd_t cmd
);

  dbe_pkg::state_t  state;
  dbe_pkg::state_t  state_next;
  dbe_pkg::mul_op_t op;
  dbe_pkg::mul_op_t op_next;
  logic [5:0]       cnt;
  logic [5:0]       cnt_next;
  logic             out_valid_next;
  logic             load_ok;

  localparam logic [5:0] MUL_LAST = 6'd4;
  localparam logic [5:0] DIV_LAST = 6'(dbe_pkg::DIV_STEPS - 1);

  assign load_ok = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    unique case (state)
      dbe_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = dbe_pkg::ST_MUL;
          op_next    = dbe_pkg::OP_SQ0;
          cnt_next   = 6'd0;
        end
      end
      dbe_pkg::ST_MUL: begin
        cnt_next = cnt + 6'd1;
        if (cnt == MUL_LAST) begin
          state_next = dbe_pkg::ST_WB;
        end
      end
      dbe_pkg::ST_WB: begin
        cnt_next = 6'd0;
        if (op == dbe_pkg::OP_PL) begin
          state_next = dbe_pkg::ST_DIV_INIT;
        end else if (op == dbe_pkg::OP_EL) begin
          state_next = dbe_pkg::ST_OUT;
        end else begin
          state_next = dbe_pkg::ST_MUL;
          op_next    = dbe_pkg::next_op(op);
        end
      end
      dbe_pkg::ST_DIV_INIT: begin
        state_next = dbe_pkg::ST_DIV;
        cnt_next   = 6'd0;
      end
      dbe_pkg::ST_DIV: begin
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_LAST) begin
          state_next = dbe_pkg::ST_MUL;
          op_next    = dbe_pkg::next_op(op);
          cnt_next   = 6'd0;
        end
      end
      dbe_pkg::ST_OUT: begin
        if (load_ok) begin
          state_next = dbe_pkg::ST_IDLE;
        end
      end
      default: state_next = dbe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.op       = op;
    cmd.pp_idx   = cnt[1:0];
    in_ready     = 1'b0;
    unique case (state)
      dbe_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dbe_pkg::ST_MUL: begin
        cmd.pp_en   = (cnt != MUL_LAST);
        cmd.acc_clr = (cnt == 6'd0);
        cmd.acc_add = (cnt != 6'd0);
      end
      dbe_pkg::ST_WB:       cmd.wb       = 1'b1;
      dbe_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      dbe_pkg::ST_DIV:      cmd.div_step = 1'b1;
      dbe_pkg::ST_OUT:      cmd.out_load = load_ok;
      default:              cmd.capture  = 1'b0;
    endcase
  end

  // hold the result valid until taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dbe_pkg::ST_IDLE;
      op        <= dbe_pkg::OP_SQ0;
      cnt       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
